// File: rtl/adts_pkg.sv
// ----------------------------------------------------------------------------
// ADTS deframer package
// Shared constants, controller states, command and status types, and the
// sampling rate table.
// ----------------------------------------------------------------------------
package adts_pkg;

	localparam int HdrMaxBytes = 10;
	localparam int IdxW        = $clog2(HdrMaxBytes);

	localparam logic [7:0] SyncByte  = 8'hFF;
	localparam logic [7:0] SyncMask  = 8'hF6;
	localparam logic [7:0] SyncMatch = 8'hF0;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SYNC2,
		ST_HEADER,
		ST_EMIT_HDR,
		ST_PAYLOAD,
		ST_TAIL
	} state_t;

	typedef enum logic [1:0] {
		OSEL_HDR,
		OSEL_BYTE,
		OSEL_MERGE,
		OSEL_CARRY
	} osel_t;

	typedef struct packed {
		logic  idx_clr;
		logic  idx_one;
		logic  idx_two;
		logic  idx_inc;
		logic  hdr_wr;
		logic  size_load;
		logic  drop_inc;
		logic  frame_end;
		logic  pay_load;
		logic  pay_dec;
		logic  carry_load;
		logic  strip_latch;
		logic  out_load;
		osel_t out_sel;
		logic  out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic byte_ff;
		logic byte_sync2;
		logic idx_last;
		logic pay_zero;
		logic rem_one;
		logic rem_zero;
		logic strip_now;
		logic id_now;
		logic realign;
		logic out_free;
	} dp_status_t;

	function automatic logic [16:0] rate_hz(input logic [3:0] sri);
		logic [16:0] r;
		unique case (sri)
			4'd0:    r = 17'd96000;
			4'd1:    r = 17'd88200;
			4'd2:    r = 17'd64000;
			4'd3:    r = 17'd48000;
			4'd4:    r = 17'd44100;
			4'd5:    r = 17'd32000;
			4'd6:    r = 17'd24000;
			4'd7:    r = 17'd22050;
			4'd8:    r = 17'd16000;
			4'd9:    r = 17'd12000;
			4'd10:   r = 17'd11025;
			4'd11:   r = 17'd8000;
			4'd12:   r = 17'd7350;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// Header length in bytes: 56 or 58 bits, plus 16 with CRC, rounded up.
	function automatic logic [3:0] header_bytes(input logic id, input logic crc);
		logic [3:0] n;
		unique case ({id, crc})
			2'b00: n = 4'd7;
			2'b10: n = 4'd8;
			2'b01: n = 4'd9;
			2'b11: n = 4'd10;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/adts_dp.sv
// ----------------------------------------------------------------------------
// ADTS deframer datapath
// Header store, counters, carry register and output register, driven by
// commands from the controller, plus the configuration register set by cfg_we.
// ----------------------------------------------------------------------------
module adts_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic [7:0]           in_byte,
	input  logic                 out_stall,
	input  adts_pkg::dp_cmd_t    cmd,
	output adts_pkg::dp_status_t status,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 frame_last,
	output logic                 frame_error,
	output logic [15:0]          dropped_bytes,
	output logic [1:0]           profile,
	output logic [3:0]           sample_rate_index,
	output logic [16:0]          sample_rate_hz,
	output logic [2:0]           channel_config,
	output logic                 id_variant,
	output logic                 has_crc,
	output logic [12:0]          frame_length
);

	adts_pkg::byte_t             hdr_q [adts_pkg::HdrMaxBytes];
	logic [adts_pkg::IdxW-1:0]   idx_q;
	logic [3:0]                  size_q;
	logic [12:0]                 rem_q;
	logic [7:0]                  carry_q;
	logic [15:0]                 drop_q;
	logic                        strip_q;
	logic                        strip_lat_q;
	logic                        out_valid_q;

	logic [12:0]                 len;
	logic                        len_short;
	logic [7:0]                  out_sel_byte;
	logic                        out_free;

	always_comb begin
		if (hdr_q[1][3]) begin
			len = {hdr_q[4], hdr_q[5][7:3]};
		end else begin
			len = {hdr_q[3][1:0], hdr_q[4], hdr_q[5][7:5]};
		end
		len_short = len < {9'd0, size_q};
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		status.byte_ff    = in_byte == adts_pkg::SyncByte;
		status.byte_sync2 = (in_byte & adts_pkg::SyncMask) == adts_pkg::SyncMatch;
		status.idx_last   = ({1'b0, idx_q} + 5'd1) >= {1'b0, size_q};
		status.pay_zero   = len <= {9'd0, size_q};
		status.rem_one    = rem_q == 13'd1;
		status.rem_zero   = rem_q == 13'd0;
		status.strip_now  = strip_q;
		status.id_now     = hdr_q[1][3];
		status.realign    = strip_lat_q && hdr_q[1][3];
		status.out_free   = out_free;
	end

	always_comb begin
		unique case (cmd.out_sel)
			adts_pkg::OSEL_HDR:   out_sel_byte = hdr_q[idx_q];
			adts_pkg::OSEL_BYTE:  out_sel_byte = in_byte;
			adts_pkg::OSEL_MERGE: out_sel_byte = carry_q | {6'd0, in_byte[7:6]};
			adts_pkg::OSEL_CARRY: out_sel_byte = carry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.hdr_wr) begin
			hdr_q[idx_q] <= in_byte;
		end
		if (cmd.pay_load) begin
			rem_q <= len - {9'd0, size_q};
		end else if (cmd.pay_dec) begin
			rem_q <= rem_q - 13'd1;
		end
		if (cmd.carry_load) begin
			carry_q <= {in_byte[5:0], 2'b00};
		end
		if (cmd.out_load) begin
			out_byte          <= out_sel_byte;
			frame_last        <= cmd.out_last;
			frame_error       <= len_short;
			dropped_bytes     <= drop_q;
			profile           <= hdr_q[2][7:6];
			sample_rate_index <= hdr_q[2][5:2];
			sample_rate_hz    <= adts_pkg::rate_hz(hdr_q[2][5:2]);
			channel_config    <= {hdr_q[2][0], hdr_q[3][7:6]};
			id_variant        <= hdr_q[1][3];
			has_crc           <= !hdr_q[1][0];
			frame_length      <= len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			size_q      <= 4'(adts_pkg::HdrMaxBytes);
			drop_q      <= '0;
			strip_q     <= 1'b0;
			strip_lat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				strip_q <= cfg_wdata;
			end
			if (cmd.strip_latch) begin
				strip_lat_q <= strip_q;
			end
			priority if (cmd.frame_end || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_one) begin
				idx_q <= adts_pkg::IdxW'(1);
			end else if (cmd.idx_two) begin
				idx_q <= adts_pkg::IdxW'(2);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + adts_pkg::IdxW'(1);
			end
			if (cmd.frame_end) begin
				size_q <= 4'(adts_pkg::HdrMaxBytes);
			end else if (cmd.size_load) begin
				size_q <= adts_pkg::header_bytes(in_byte[3], !in_byte[0]);
			end
			if (cmd.frame_end) begin
				drop_q <= '0;
			end else if (cmd.drop_inc && drop_q != 16'hFFFF) begin
				drop_q <= drop_q + 16'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < adts_pkg::IdxW'(adts_pkg::HdrMaxBytes))
		else $error("header index out of range");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		size_q >= 4'd7 && size_q <= 4'd10)
		else $error("header size out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register overwritten while held");
`endif

endmodule

// File: rtl/adts_ctrl.sv
// ----------------------------------------------------------------------------
// ADTS deframer controller
// State machine that hunts sync, captures the header, sequences the header
// burst, the payload and the realignment tail byte.
// ----------------------------------------------------------------------------
module adts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  adts_pkg::dp_status_t status,
	output adts_pkg::dp_cmd_t    cmd
);

	adts_pkg::state_t state_q;
	adts_pkg::state_t state_nxt;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adts_pkg::ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = 1'b1;
		unique case (state_q)
			adts_pkg::ST_HUNT, adts_pkg::ST_SYNC2,
			adts_pkg::ST_HEADER, adts_pkg::ST_PAYLOAD: in_stall = !status.out_free;
			default: in_stall = 1'b1;
		endcase
		accept = in_valid && !in_stall;

		unique case (state_q)
			adts_pkg::ST_HUNT: begin
				if (accept) begin
					if (status.byte_ff) begin
						cmd.hdr_wr  = 1'b1;
						cmd.idx_one = 1'b1;
						state_nxt   = adts_pkg::ST_SYNC2;
					end else begin
						cmd.drop_inc = 1'b1;
					end
				end
			end
			adts_pkg::ST_SYNC2: begin
				if (accept) begin
					if (status.byte_sync2) begin
						cmd.hdr_wr    = 1'b1;
						cmd.idx_two   = 1'b1;
						cmd.size_load = 1'b1;
						state_nxt     = adts_pkg::ST_HEADER;
					end else if (!status.byte_ff) begin
						cmd.drop_inc = 1'b1;
						cmd.idx_clr  = 1'b1;
						state_nxt    = adts_pkg::ST_HUNT;
					end
				end
			end
			adts_pkg::ST_HEADER: begin
				if (accept) begin
					cmd.hdr_wr = 1'b1;
					if (status.idx_last) begin
						cmd.strip_latch = 1'b1;
						cmd.pay_load    = !status.pay_zero;
						if (!status.strip_now) begin
							cmd.idx_clr = 1'b1;
							state_nxt   = adts_pkg::ST_EMIT_HDR;
						end else if (status.id_now) begin
							cmd.carry_load = 1'b1;
							state_nxt      = status.pay_zero ? adts_pkg::ST_TAIL
							                                 : adts_pkg::ST_PAYLOAD;
						end else if (status.pay_zero) begin
							cmd.frame_end = 1'b1;
							state_nxt     = adts_pkg::ST_HUNT;
						end else begin
							state_nxt = adts_pkg::ST_PAYLOAD;
						end
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			adts_pkg::ST_EMIT_HDR: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = adts_pkg::OSEL_HDR;
					cmd.out_last = status.pay_zero && status.idx_last;
					if (status.idx_last) begin
						if (status.pay_zero) begin
							cmd.frame_end = 1'b1;
							state_nxt     = adts_pkg::ST_HUNT;
						end else begin
							state_nxt = adts_pkg::ST_PAYLOAD;
						end
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			adts_pkg::ST_PAYLOAD: begin
				if (accept) begin
					cmd.pay_dec  = 1'b1;
					cmd.out_load = 1'b1;
					if (status.realign) begin
						cmd.out_sel    = adts_pkg::OSEL_MERGE;
						cmd.carry_load = 1'b1;
						if (status.rem_one) begin
							state_nxt = adts_pkg::ST_TAIL;
						end
					end else begin
						cmd.out_sel  = adts_pkg::OSEL_BYTE;
						cmd.out_last = status.rem_one;
						if (status.rem_one) begin
							cmd.frame_end = 1'b1;
							state_nxt     = adts_pkg::ST_HUNT;
						end
					end
				end
			end
			adts_pkg::ST_TAIL: begin
				if (status.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_sel   = adts_pkg::OSEL_CARRY;
					cmd.out_last  = 1'b1;
					cmd.frame_end = 1'b1;
					state_nxt     = adts_pkg::ST_HUNT;
				end
			end
			default: begin
				state_nxt = adts_pkg::ST_HUNT;
			end
		endcase
	end

`ifndef SYNTH
	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == adts_pkg::ST_PAYLOAD |-> !status.rem_zero)
		else $error("payload state entered with nothing left");

	a_burst_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adts_pkg::ST_EMIT_HDR || state_q == adts_pkg::ST_TAIL) |-> in_stall)
		else $error("request taken during header burst or tail");

	a_tail_from: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == adts_pkg::ST_TAIL) |-> $past(status.realign || status.strip_now))
		else $error("tail byte outside strip mode");
`endif

endmodule

// File: rtl/adts_frame_deframer.sv
// ----------------------------------------------------------------------------
// ADTS frame deframer
// Finds ADTS frames in a byte stream and emits header and payload bytes with
// the decoded header fields of the current frame.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per request on in_byte, in_valid/in_stall.
// Output channel: one byte per request with frame_last, frame_error, the drop
// count and the header fields, out_valid/out_stall.
// Configuration: cfg_we writes cfg_wdata to strip_header; write it only while
// the block is idle. It is sampled when each header completes.
// Throughput: one input byte per cycle while hunting, capturing the header
// and passing payload, as long as the output is not stalled. With the header
// passed through, the final header byte starts a burst of the whole header,
// 7 to 10 bytes, from the header store, during which the input is stalled;
// in realign mode the frame's tail byte is an extra output from the carry
// register, during which the input is stalled as well.
// Latency: a payload byte appears on the output the cycle after it is taken.
// Reset: returns to hunting for sync, strip_header and the drop count clear.
// Receiver stall: the output register holds, and in_stall is high for as long
// as it holds a result that has not been taken.
// ----------------------------------------------------------------------------
module adts_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_last,
	output logic        frame_error,
	output logic [15:0] dropped_bytes,
	output logic [1:0]  profile,
	output logic [3:0]  sample_rate_index,
	output logic [16:0] sample_rate_hz,
	output logic [2:0]  channel_config,
	output logic        id_variant,
	output logic        has_crc,
	output logic [12:0] frame_length
);

	adts_pkg::dp_cmd_t    cmd;
	adts_pkg::dp_status_t status;

	adts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	adts_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_byte           (in_byte),
		.out_stall         (out_stall),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.out_byte          (out_byte),
		.frame_last        (frame_last),
		.frame_error       (frame_error),
		.dropped_bytes     (dropped_bytes),
		.profile           (profile),
		.sample_rate_index (sample_rate_index),
		.sample_rate_hz    (sample_rate_hz),
		.channel_config    (channel_config),
		.id_variant        (id_variant),
		.has_crc           (has_crc),
		.frame_length      (frame_length)
	);

endmodule
